[src/tpp_pkg.sv]
// ----------------------------------------------------------------------------
// tpp_pkg
// shared types and constants of the timecode pid pll
// ----------------------------------------------------------------------------
package tpp_pkg;

	localparam logic [31:0] ONE_Q24     = 32'd16777216;
	localparam logic [63:0] RATIO_MIN   = 64'd8388608;
	localparam logic [63:0] RATIO_MAX   = 64'd33554432;
	localparam logic [63:0] ONE_SEC_Q32 = 64'd4294967296;
	localparam logic [31:0] MIN_TICK    = 32'd66;
	localparam logic [63:0] LOCK_MAG    = 64'd4294967;
	localparam logic [63:0] S64_MAX     = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;

	localparam logic [31:0] KP_RESET  = 32'd14758011;
	localparam logic [31:0] KI_RESET  = 32'd6623376;
	localparam logic [31:0] KD_RESET  = 32'd0;
	localparam logic [62:0] MAXI_RESET = 63'd10879276715;

	typedef enum logic [1:0] {
		REG_KP   = 2'd0,
		REG_KI   = 2'd1,
		REG_KD   = 2'd2,
		REG_MAXI = 2'd3
	} reg_idx_t;

	// datapath operations, one per sequencer step
	typedef enum logic [3:0] {
		OP_ERR,
		OP_CHG,
		OP_JUMP,
		OP_DIV_START,
		OP_INT_MUL,
		OP_INT_ACC,
		OP_P_MUL,
		OP_I_MUL,
		OP_D_MUL,
		OP_RATIO,
		OP_Q_MUL,
		OP_Q_ADD,
		OP_Q_RAW,
		OP_NONE
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_CHG,
		ST_JUMP,
		ST_INT_MUL,
		ST_INT_ACC,
		ST_P_MUL,
		ST_I_MUL,
		ST_DIV_WAIT,
		ST_D_MUL,
		ST_RATIO,
		ST_Q_MUL,
		ST_Q_ADD,
		ST_MUL_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic mul_go;
	} cmd_t;

	typedef struct packed {
		logic big_jump;
		logic mul_done;
		logic div_done;
	} sts_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	function automatic logic [63:0] signed_mag(input logic [63:0] m, input logic neg);
		if (neg)
			return m[63] ? S64_MIN : (64'd0 - m);
		return m[63] ? S64_MAX : m;
	endfunction

endpackage

[src/tpp_mul.sv]
// ----------------------------------------------------------------------------
// tpp_mul
// sign-magnitude 64x64 multiply, one 32x32 partial product a cycle,
// shift right and saturate
// ----------------------------------------------------------------------------
module tpp_mul
	import tpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [5:0]  sh,
	output logic        done,
	output logic [63:0] res
);

	logic [63:0]  ua_q, b_q;
	logic         neg_q;
	logic [5:0]   sh_q;
	logic [2:0]   step_q;
	logic         busy_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_s1;
	logic [6:0]   pos_s1;
	logic         pv_s1;
	logic [31:0]  xa, xb;
	logic [127:0] full;

	always_comb begin
		xa = step_q[0] ? ua_q[63:32] : ua_q[31:0];
		xb = step_q[1] ? b_q[63:32] : b_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			pv_s1  <= 1'b0;
			done   <= 1'b0;
		end else begin
			done  <= 1'b0;
			pv_s1 <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q[2]) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					pv_s1  <= 1'b1;
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ua_q  <= mag64(a);
			neg_q <= a[63];
			b_q   <= b;
			sh_q  <= sh;
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + ({64'd0, pp_s1} << pos_s1);
		end
		pp_s1  <= xa * xb;
		pos_s1 <= {step_q[1:0] == 2'd3, step_q[1:0] == 2'd1 || step_q[1:0] == 2'd2, 5'd0};
	end

	// step 4 adds the last product at the same edge that raises done, so res is valid with done
	always_comb begin
		full = acc_q >> sh_q;
		if (full[127:64] != 64'd0)
			res = neg_q ? S64_MIN : S64_MAX;
		else
			res = signed_mag(full[63:0], neg_q);
	end

endmodule

[src/tpp_div.sv]
// ----------------------------------------------------------------------------
// tpp_div
// restoring divider, one quotient bit a cycle, 80-bit dividend by 32-bit tick
// ----------------------------------------------------------------------------
module tpp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [79:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [79:0] quo
);

	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo[79]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd79) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			den_q <= den;
			quo   <= num;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo   <= {quo[78:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo   <= {quo[78:0], 1'b0};
			end
		end
	end

endmodule

[src/tpp_datapath.sv]
// ----------------------------------------------------------------------------
// tpp_datapath
// loop state, error terms and the shared multiplier and the divider
// ----------------------------------------------------------------------------
module tpp_datapath
	import tpp_pkg::*;
#(
	parameter int LOCK_COUNT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        load,
	input  logic [63:0] master_in,
	input  logic [63:0] local_in,
	input  logic [31:0] delta_in,
	input  logic [31:0] kp,
	input  logic [31:0] ki,
	input  logic [31:0] kd,
	input  logic [62:0] maxi,
	output logic [31:0] ratio,
	output logic [63:0] phase,
	output logic        lock,
	output logic        started,
	output logic [63:0] corr
);

	logic [63:0] master_q, local_q, err_q, chg_q, prev_q, integ_q, acc_q, deriv_q;
	logic [31:0] dt_q;
	logic [3:0]  stable_q;
	logic [63:0] ma, mb, mres, lim, isum, acc_c;
	logic [5:0]  msh;
	logic        mdone, ddone, div_go;
	logic [79:0] dq;
	logic [31:0] tick;
	logic [4:0]  stable_n;

	assign tick   = (dt_q < MIN_TICK) ? MIN_TICK : dt_q;
	assign div_go = cmd.op == OP_DIV_START;
	assign lim    = {1'b0, maxi};

	always_comb begin
		ma = err_q;
		mb = {32'd0, dt_q};
		msh = 6'd16;
		case (cmd.op)
			OP_P_MUL: begin ma = err_q;   mb = {32'd0, kp}; msh = 6'd32; end
			OP_I_MUL: begin ma = integ_q; mb = {32'd0, ki}; msh = 6'd32; end
			OP_D_MUL: begin ma = deriv_q; mb = {32'd0, kd}; msh = 6'd32; end
			OP_Q_MUL: begin ma = local_q; mb = {32'd0, ratio}; msh = 6'd24; end
			default: ;
		endcase
	end

	tpp_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(cmd.mul_go), .a(ma), .b(mb), .sh(msh),
		.done(mdone), .res(mres)
	);

	tpp_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num({mag64(chg_q), 16'd0}),
		.den(tick), .done(ddone), .quo(dq)
	);

	assign sts.big_jump = mag64(chg_q) > ONE_SEC_Q32;
	assign sts.mul_done = mdone;
	assign sts.div_done = ddone;

	always_comb begin
		isum = sat_add(integ_q, mres);
		if ($signed(isum) > $signed(lim))
			isum = lim;
		if ($signed(isum) < $signed(64'd0 - lim))
			isum = 64'd0 - lim;
		acc_c = acc_q;
		if ($signed(acc_c) < $signed(RATIO_MIN))
			acc_c = RATIO_MIN;
		if ($signed(acc_c) > $signed(RATIO_MAX))
			acc_c = RATIO_MAX;
		stable_n = {1'b0, stable_q} + ((stable_q == 4'd15) ? 5'd0 : 5'd1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			master_q <= master_in;
			local_q  <= local_in;
			dt_q     <= delta_in;
		end
		case (cmd.op)
			OP_ERR:  err_q <= sat_sub(master_q, local_q);
			OP_CHG:  chg_q <= sat_sub(err_q, prev_q);
			OP_P_MUL: if (mdone) acc_q <= sat_add({32'd0, ONE_Q24}, mres);
			OP_I_MUL: if (mdone) acc_q <= sat_add(acc_q, mres);
			OP_D_MUL: if (mdone) acc_q <= sat_add(acc_q, mres);
			OP_INT_MUL: if (ddone) deriv_q <= signed_mag(dq[63:0], chg_q[63]);
			default: ;
		endcase
		if (cmd.op == OP_INT_ACC && ddone)
			deriv_q <= signed_mag(dq[63:0], chg_q[63]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			prev_q   <= '0;
			phase    <= '0;
			ratio    <= ONE_Q24;
			stable_q <= '0;
			lock     <= 1'b0;
			started  <= 1'b0;
			corr     <= '0;
		end else begin
			case (cmd.op)
				OP_JUMP: begin
					started <= 1'b1;
					corr    <= '0;
					if (sts.big_jump) begin
						integ_q  <= '0;
						ratio    <= ONE_Q24;
						stable_q <= '0;
						lock     <= 1'b0;
						phase    <= err_q;
						prev_q   <= err_q;
					end
				end
				OP_INT_ACC: if (mdone) integ_q <= isum;
				OP_RATIO: begin
					ratio  <= acc_c[31:0];
					phase  <= err_q;
					prev_q <= err_q;
					if (mag64(err_q) <= LOCK_MAG) begin
						stable_q <= stable_n[3:0];
						if (stable_n >= 5'(LOCK_COUNT))
							lock <= 1'b1;
					end else begin
						stable_q <= '0;
						lock     <= 1'b0;
					end
				end
				OP_Q_ADD: corr <= sat_add(mres, phase);
				OP_Q_RAW: corr <= local_q;
				default: ;
			endcase
		end
	end

endmodule

[src/tpp_ctrl.sv]
// ----------------------------------------------------------------------------
// tpp_ctrl
// sequencer for update and query transactions
// ----------------------------------------------------------------------------
module tpp_ctrl
	import tpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_type,
	input  logic started,
	input  logic out_stall,
	output logic in_stall,
	output logic out_valid,
	output logic res_load,
	output logic load,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_n;
	logic   mul_pending_q;
	logic   entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mul_pending_q <= 1'b0;
			entry_q       <= 1'b0;
		end else begin
			state_q       <= state_n;
			mul_pending_q <= cmd.mul_go;
			entry_q       <= state_n != state_q;
		end
	end

	// result registers load once the previous result has gone
	assign res_load = state_q == ST_OUT && !out_valid;

	// out_valid is its own register so a finished result holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (res_load)
			out_valid <= 1'b1;
		else if (out_valid && !out_stall)
			out_valid <= 1'b0;
	end

	always_comb begin
		state_n    = state_q;
		cmd.op     = OP_NONE;
		cmd.mul_go = 1'b0;
		in_stall   = 1'b1;
		load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					load    = 1'b1;
					state_n = in_type ? (started ? ST_Q_MUL : ST_Q_ADD) : ST_ERR;
				end
			end
			ST_ERR:  begin cmd.op = OP_ERR; state_n = ST_CHG; end
			ST_CHG:  begin cmd.op = OP_CHG; state_n = ST_JUMP; end
			ST_JUMP: begin
				cmd.op = OP_JUMP;
				state_n = sts.big_jump ? ST_OUT : ST_INT_MUL;
			end
			ST_INT_MUL: begin
				cmd.op = OP_DIV_START; cmd.mul_go = 1'b1; state_n = ST_INT_ACC;
			end
			ST_INT_ACC: begin
				cmd.op = OP_INT_ACC;
				if (sts.mul_done && !mul_pending_q) begin
					state_n = ST_P_MUL; cmd.mul_go = 1'b0;
				end
			end
			ST_P_MUL: begin
				cmd.op = OP_P_MUL;
				if (sts.mul_done) state_n = ST_I_MUL;
			end
			ST_I_MUL: begin
				cmd.op = OP_I_MUL;
				if (sts.mul_done) state_n = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				cmd.op = OP_INT_MUL;
				if (sts.div_done) state_n = ST_D_MUL;
			end
			ST_D_MUL: begin
				cmd.op = OP_D_MUL;
				if (sts.mul_done) state_n = ST_RATIO;
			end
			ST_RATIO: begin cmd.op = OP_RATIO; state_n = ST_OUT; end
			ST_Q_MUL: begin
				cmd.op = OP_Q_MUL;
				if (sts.mul_done) state_n = ST_Q_ADD;
			end
			ST_Q_ADD: begin
				cmd.op = started ? OP_Q_ADD : OP_Q_RAW; state_n = ST_OUT;
			end
			ST_MUL_WAIT: state_n = ST_IDLE;
			ST_OUT: if (!out_valid) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
		// start the multiplier in the first cycle of every gain and query multiply step,
		// once that step's operands are selected
		if (entry_q && (state_q == ST_P_MUL || state_q == ST_I_MUL ||
				state_q == ST_D_MUL || state_q == ST_Q_MUL))
			cmd.mul_go = 1'b1;
	end

endmodule

[src/timecode_pid_pll_top.sv]
// ----------------------------------------------------------------------------
// timecode_pid_pll_top
// pid software pll for timecode: updates and corrected time queries
// ----------------------------------------------------------------------------
//  channel | direction  | handshake           | payload
//  in      | to block   | in_valid/in_stall   | req_type master_time local_time delta_time
//  out     | from block | out_valid/out_stall | frequency_ratio phase_error locked
//          |            |                     | corrected_time
//  cfg     | to block   | apb psel/penable    | paddr pwdata prdata
//
// one transaction at a time; an update is paced by the restoring divider for the
// derivative (the integral and the two gain multiplies overlap it) followed by the
// derivative multiply; each multiplier pass works through four partial products;
// the next transaction can be taken in the cycle its result appears; a large jump skips
// the loop filter, and a query skips its multiply before any update
// reset clears loop state, ratio to 1.0 and gains to their defaults
// a stalled result holds in the output registers while the next transaction is worked;
// a later result waits until the earlier one has gone
// ----------------------------------------------------------------------------
module timecode_pid_pll_top
	import tpp_pkg::*;
#(
	parameter int LOCK_COUNT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [63:0] master_time,
	input  logic [63:0] local_time,
	input  logic [31:0] delta_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [25:0] frequency_ratio,
	output logic [63:0] phase_error,
	output logic        locked,
	output logic [63:0] corrected_time,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [31:0] kp_q, ki_q, kd_q;
	logic [62:0] maxi_q;
	logic [31:0] ratio;
	logic [63:0] dp_phase, dp_corr;
	logic        dp_lock;
	logic        started, load, res_load;
	logic [25:0] ratio_q;
	logic [63:0] phase_q, corr_q;
	logic        lock_q;
	cmd_t        cmd;
	sts_t        sts;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:3]);

	// register file, 8-byte stride since max_integral is 63 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= KP_RESET;
			ki_q   <= KI_RESET;
			kd_q   <= KD_RESET;
			maxi_q <= MAXI_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_KP:   kp_q   <= pwdata[31:0];
				REG_KI:   ki_q   <= pwdata[31:0];
				REG_KD:   kd_q   <= pwdata[31:0];
				REG_MAXI: maxi_q <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KP:   prdata = {32'd0, kp_q};
			REG_KI:   prdata = {32'd0, ki_q};
			REG_KD:   prdata = {32'd0, kd_q};
			REG_MAXI: prdata = {1'b0, maxi_q};
			default:  prdata = '0;
		endcase
	end

	tpp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_type(req_type),
		.started(started), .out_stall(out_stall), .in_stall(in_stall),
		.out_valid(out_valid), .res_load(res_load), .load(load), .cmd(cmd), .sts(sts)
	);

	tpp_datapath #(.LOCK_COUNT(LOCK_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .load(load),
		.master_in(master_time), .local_in(local_time), .delta_in(delta_time),
		.kp(kp_q), .ki(ki_q), .kd(kd_q), .maxi(maxi_q), .ratio(ratio),
		.phase(dp_phase), .lock(dp_lock), .started(started), .corr(dp_corr)
	);

	// result registers, so the loop can move on while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= ONE_Q24[25:0];
			phase_q <= '0;
			lock_q  <= 1'b0;
			corr_q  <= '0;
		end else if (res_load) begin
			ratio_q <= ratio[25:0];
			phase_q <= dp_phase;
			lock_q  <= dp_lock;
			corr_q  <= dp_corr;
		end
	end

	assign frequency_ratio = ratio_q;
	assign phase_error     = phase_q;
	assign locked          = lock_q;
	assign corrected_time  = corr_q;

	// ratio always in range
	a_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		ratio >= 32'd8388608 && ratio <= 32'd33554432)
		else $error("ratio out of range");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(corrected_time) &&
			$stable(phase_error))
		else $error("stalled result changed");

	// lock implies a phase error within the lock band
	a_lock: assert property (@(posedge clk) disable iff (!arst_n)
		locked |-> mag64(phase_error) <= LOCK_MAG)
		else $error("lock with large error");

endmodule
